// ===== rtl/gclp_pkg.sv =====
// gclp_pkg: shared types, character codes and status codes of the command line parser
// no dependencies; imported by every module of the block except gclp_fifo
package gclp_pkg;

	// request kinds
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_POLL = 1'b1;

	// character codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// keyword match progress
	localparam logic [2:0] KW_DONE = 3'd4;
	localparam logic [2:0] KW_FAIL = 3'd7;

	// token positions of interest
	localparam logic [2:0] TOK_NONE = 3'd0;
	localparam logic [2:0] TOK_KW   = 3'd1;
	localparam logic [2:0] TOK_NUM1 = 3'd2;
	localparam logic [2:0] TOK_NUM2 = 3'd3;
	localparam logic [2:0] TOK_MAX  = 3'd4;

	// result status codes
	typedef logic [2:0] status_t;
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_BUSY     = 3'd1;
	localparam status_t ST_INVALID  = 3'd2;
	localparam status_t ST_TOO_LONG = 3'd3;
	localparam status_t ST_COMPLETE = 3'd4;

	// command kinds from front to back
	typedef logic [1:0] cmd_kind_t;
	localparam cmd_kind_t CMD_POLL = 2'd0;
	localparam cmd_kind_t CMD_LINE = 2'd1;
	localparam cmd_kind_t CMD_LONG = 2'd2;

	typedef struct packed {
		cmd_kind_t kind;
		logic      bad;
		logic      at_target;
	} gclp_cmd_t;

	typedef struct packed {
		logic sign;
		logic bad;
		logic digit;
		logic neg;
	} num_flags_t;

	// upper-case letters of the keyword
	function automatic logic [7:0] kw_char(input logic [1:0] idx);
		logic [7:0] ch;
		unique case (idx)
			2'd0: ch = 8'h47;
			2'd1: ch = 8'h4F;
			2'd2: ch = 8'h54;
			2'd3: ch = 8'h4F;
			default: ch = 8'h4F;
		endcase
		return ch;
	endfunction

endpackage

// ===== rtl/gclp_fifo.sv =====
// gclp_fifo: small register queue with full/empty flags
// no package dependencies; used for the command and result queues
module gclp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/gclp_front.sv =====
// gclp_front: byte parser; builds the line, matches the keyword, accumulates numbers
// depends on gclp_pkg; emits one command per non-empty line end, overlong byte or poll
module gclp_front
	import gclp_pkg::*;
#(
	parameter int LINE_LIMIT  = 64,
	parameter int TARGET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   req_type,
	input  logic [7:0]             rx_byte,
	input  logic                   motors_at_target,
	output logic                   cmd_push,
	output gclp_cmd_t              cmd,
	output logic [TARGET_BITS-1:0] cmd_a,
	output logic [TARGET_BITS-1:0] cmd_b
);
	localparam int CW = $clog2(LINE_LIMIT);
	localparam int PW = TARGET_BITS + 4;

	logic [CW-1:0]          count_q, count_d;
	logic [2:0]             tok_q, tok_d;
	logic                   inside_q, inside_d;
	logic [2:0]             kw_q, kw_d;
	logic [TARGET_BITS-1:0] acc_q, acc_d;
	num_flags_t             flags_q, flags_d;
	logic                   line_bad_q, line_bad_d;
	logic [TARGET_BITS-1:0] first_q, first_d;

	logic                   num_ok;
	logic [TARGET_BITS-1:0] num_value;
	logic [PW-1:0]          cap_w;

	assign cap_w  = PW'(1) << (TARGET_BITS - 1);
	assign num_ok = flags_q.digit && !flags_q.bad;

	// signed value of the current number, positive side clipped
	always_comb begin
		if (flags_q.neg) begin
			num_value = '0 - acc_q;
		end else if (acc_q[TARGET_BITS-1]) begin
			num_value = {1'b0, {(TARGET_BITS-1){1'b1}}};
		end else begin
			num_value = acc_q;
		end
	end

	assign cmd_a = first_q;
	assign cmd_b = num_value;

	// per-byte parse update
	always_comb begin
		logic                   blank, new_tok, is_digit, lead;
		logic [2:0]             tp_n;
		logic [7:0]             kc;
		logic [TARGET_BITS-1:0] acc_b;
		num_flags_t             flags_b;
		logic [PW-1:0]          prod;

		count_d    = count_q;
		tok_d      = tok_q;
		inside_d   = inside_q;
		kw_d       = kw_q;
		acc_d      = acc_q;
		flags_d    = flags_q;
		line_bad_d = line_bad_q;
		first_d    = first_q;
		cmd_push   = 1'b0;
		cmd        = '{kind: CMD_POLL, bad: 1'b0, at_target: motors_at_target};

		blank    = (rx_byte == CH_SP) || (rx_byte == CH_TAB);
		new_tok  = !inside_q;
		tp_n     = (new_tok && (tok_q < TOK_MAX)) ? tok_q + 3'd1 : tok_q;
		kc       = ((rx_byte >= CH_LA) && (rx_byte <= CH_LZ)) ? rx_byte - CASE_OFS : rx_byte;
		is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);
		if (new_tok && ((tp_n == TOK_NUM1) || (tp_n == TOK_NUM2))) begin
			acc_b   = '0;
			flags_b = '0;
		end else begin
			acc_b   = acc_q;
			flags_b = flags_q;
		end
		lead = !flags_b.digit && !flags_b.sign;
		prod = (PW'(acc_b) << 3) + (PW'(acc_b) << 1) + PW'(rx_byte[3:0]);

		if (in_valid) begin
			if (req_type == REQ_POLL) begin
				cmd_push = 1'b1;
			end else if (rx_byte == CH_CR) begin
				// carriage return dropped
			end else if (rx_byte == CH_LF) begin
				cmd_push  = (tok_q != TOK_NONE);
				cmd.kind  = CMD_LINE;
				cmd.bad   = (kw_q != KW_DONE) || (tok_q < TOK_NUM2) || line_bad_q || !num_ok;
				count_d    = '0;
				tok_d      = TOK_NONE;
				inside_d   = 1'b0;
				kw_d       = '0;
				acc_d      = '0;
				flags_d    = '0;
				line_bad_d = 1'b0;
			end else if (count_q >= CW'(LINE_LIMIT - 1)) begin
				cmd_push   = 1'b1;
				cmd.kind   = CMD_LONG;
				count_d    = '0;
				tok_d      = TOK_NONE;
				inside_d   = 1'b0;
				kw_d       = '0;
				acc_d      = '0;
				flags_d    = '0;
				line_bad_d = 1'b0;
			end else begin
				count_d = count_q + 1'b1;
				if (blank) begin
					inside_d = 1'b0;
				end else begin
					inside_d = 1'b1;
					tok_d    = tp_n;
					// first number is frozen when the second number token starts
					if (new_tok && (tp_n == TOK_NUM2)) begin
						if (num_ok) first_d = num_value;
						else line_bad_d = 1'b1;
					end
					if (tp_n == TOK_KW) begin
						if (kw_q[2]) kw_d = KW_FAIL;
						else kw_d = (kc == kw_char(kw_q[1:0])) ? kw_q + 3'd1 : KW_FAIL;
					end else if ((tp_n == TOK_NUM1) || (tp_n == TOK_NUM2)) begin
						acc_d   = acc_b;
						flags_d = flags_b;
						if (!flags_b.bad) begin
							if (is_digit) begin
								acc_d         = (prod > cap_w) ? TARGET_BITS'(cap_w)
								                               : TARGET_BITS'(prod);
								flags_d.digit = 1'b1;
							end else if (lead && ((rx_byte == CH_VT) || (rx_byte == CH_FF))) begin
								// leading white space skipped
							end else if (lead && ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS))) begin
								flags_d.sign = 1'b1;
								flags_d.neg  = (rx_byte == CH_MINUS);
							end else begin
								flags_d.bad = 1'b1;
							end
						end
					end
				end
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			tok_q      <= TOK_NONE;
			inside_q   <= 1'b0;
			kw_q       <= '0;
			acc_q      <= '0;
			flags_q    <= '0;
			line_bad_q <= 1'b0;
			first_q    <= '0;
		end else begin
			count_q    <= count_d;
			tok_q      <= tok_d;
			inside_q   <= inside_d;
			kw_q       <= kw_d;
			acc_q      <= acc_d;
			flags_q    <= flags_d;
			line_bad_q <= line_bad_d;
			first_q    <= first_d;
		end
	end

endmodule

// ===== rtl/gclp_back.sv =====
// gclp_back: executes parsed commands against the moving flag and forms results
// depends on gclp_pkg; reads the command queue, writes the result queue
module gclp_back
	import gclp_pkg::*;
#(
	parameter int TARGET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_empty,
	input  gclp_cmd_t              cmd,
	input  logic [TARGET_BITS-1:0] cmd_a,
	input  logic [TARGET_BITS-1:0] cmd_b,
	output logic                   cmd_pop,
	input  logic                   res_full,
	output logic                   res_push,
	output status_t                res_status,
	output logic [TARGET_BITS-1:0] res_a,
	output logic [TARGET_BITS-1:0] res_b
);
	logic moving_q, moving_d;

	assign cmd_pop = !cmd_empty && !res_full;

	// command decode
	always_comb begin
		moving_d   = moving_q;
		res_push   = 1'b0;
		res_status = ST_OK;
		res_a      = '0;
		res_b      = '0;
		if (cmd_pop) begin
			unique case (cmd.kind)
				CMD_POLL: begin
					if (moving_q && cmd.at_target) begin
						moving_d   = 1'b0;
						res_push   = 1'b1;
						res_status = ST_COMPLETE;
					end
				end
				CMD_LINE: begin
					res_push = 1'b1;
					if (cmd.bad) begin
						res_status = ST_INVALID;
					end else if (moving_q && !cmd.at_target) begin
						res_status = ST_BUSY;
					end else begin
						moving_d   = 1'b1;
						res_status = ST_OK;
						res_a      = cmd_a;
						res_b      = cmd_b;
					end
				end
				CMD_LONG: begin
					res_push   = 1'b1;
					res_status = ST_TOO_LONG;
				end
				default: begin
				end
			endcase
		end
	end

	// motion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q <= 1'b0;
		end else begin
			moving_q <= moving_d;
		end
	end

endmodule

// ===== rtl/goto_command_line_parser.sv =====
// A result passes two registered queues on its way from the request that causes it to
// the result ports (front parse into the command queue, then back execute into the result queue).
// Throughput: one request per cycle while the command queue is not full; one parse update per byte.
// Backpressure: full rises when the four-entry command queue fills.
// Reset: arst_n clears parser state, moving flag and both queues at once; no clearing pass.
module goto_command_line_parser
	import gclp_pkg::*;
#(
	parameter int LINE_LIMIT  = 64,
	parameter int TARGET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic                   req_type,
	input  logic [7:0]             rx_byte,
	input  logic                   motors_at_target,
	output logic                   empty,
	input  logic                   pop,
	output logic [2:0]             status_code,
	output logic [TARGET_BITS-1:0] target_a,
	output logic [TARGET_BITS-1:0] target_b
);
	localparam int QDEPTH = 4;
	localparam int CMD_W  = $bits(gclp_cmd_t) + 2 * TARGET_BITS;
	localparam int RES_W  = $bits(status_t) + 2 * TARGET_BITS;

	logic                   in_valid;
	logic                   f_push, c_empty, c_full, c_pop;
	gclp_cmd_t              f_cmd, c_cmd;
	logic [TARGET_BITS-1:0] f_a, f_b, c_a, c_b;
	logic                   r_push, r_full;
	status_t                r_status;
	logic [TARGET_BITS-1:0] r_a, r_b;

	assign in_valid = push && !c_full;
	assign full     = c_full;

	// front: parse
	gclp_front #(
		.LINE_LIMIT (LINE_LIMIT),
		.TARGET_BITS(TARGET_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.req_type        (req_type),
		.rx_byte         (rx_byte),
		.motors_at_target(motors_at_target),
		.cmd_push        (f_push),
		.cmd             (f_cmd),
		.cmd_a           (f_a),
		.cmd_b           (f_b)
	);

	// command queue between front and back
	gclp_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(QDEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_push),
		.wdata ({f_cmd, f_a, f_b}),
		.full  (c_full),
		.pop   (c_pop),
		.rdata ({c_cmd, c_a, c_b}),
		.empty (c_empty)
	);

	// back: execute
	gclp_back #(
		.TARGET_BITS(TARGET_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (c_empty),
		.cmd       (c_cmd),
		.cmd_a     (c_a),
		.cmd_b     (c_b),
		.cmd_pop   (c_pop),
		.res_full  (r_full),
		.res_push  (r_push),
		.res_status(r_status),
		.res_a     (r_a),
		.res_b     (r_b)
	);

	// result queue toward the consumer
	gclp_fifo #(
		.WIDTH(RES_W),
		.DEPTH(QDEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (r_push),
		.wdata ({r_status, r_a, r_b}),
		.full  (r_full),
		.pop   (pop),
		.rdata ({status_code, target_a, target_b}),
		.empty (empty)
	);

endmodule

// ===== rtl/gclp_checker.sv =====
// gclp_checker: port-level assertions for the command line parser
// depends on gclp_pkg; bound to goto_command_line_parser at the end of this file
module gclp_checker
	import gclp_pkg::*;
#(
	parameter int TARGET_BITS = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   empty,
	input logic                   pop,
	input logic [2:0]             status_code,
	input logic [TARGET_BITS-1:0] target_a,
	input logic [TARGET_BITS-1:0] target_b
);

	// result queue comes out of reset empty
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result queue not empty after reset");

	// only defined status codes are shown
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status_code <= ST_COMPLETE))
		else $error("undefined status code");

	// targets carry data only with an ok status
	a_targets_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status_code != ST_OK)) |-> ((target_a == '0) && (target_b == '0)))
		else $error("targets nonzero on non-ok result");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status_code) && $stable(target_a)
		                      && $stable(target_b)))
		else $error("waiting result changed");

endmodule

bind goto_command_line_parser gclp_checker #(.TARGET_BITS(TARGET_BITS)) u_gclp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.status_code(status_code),
	.target_a   (target_a),
	.target_b   (target_b)
);
